### design/ptu_pkg.sv
`default_nettype none

package ptu_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 7;

    localparam logic [15:0] DAMP_RESET = 16'd63570;

    localparam logic [1:0] REQ_SPAWN = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] KIND_SPAWNED = 3'd0;
    localparam logic [2:0] KIND_DROPPED = 3'd1;
    localparam logic [2:0] KIND_RECORD  = 3'd2;
    localparam logic [2:0] KIND_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_CLEARED = 3'd4;

    typedef struct packed {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [19:0] vx;
        logic signed [19:0] vy;
        logic [15:0]        life_left;
        logic [15:0]        life_max;
        logic [15:0]        size_max;
        logic [15:0]        angle;
        logic signed [15:0] spin;
        logic [23:0]        colour;
    } ptu_entry_t;

    localparam int ENTRY_W = $bits(ptu_entry_t);

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [23:0] out_x;
        logic signed [23:0] out_y;
        logic [15:0]        out_radius;
        logic [15:0]        out_angle;
        logic [23:0]        rgb_out;
        logic [7:0]         alpha;
        logic               last;
        logic [6:0]         live_count;
    } ptu_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_RD,
        S_T_MUL,
        S_T_WR,
        S_EMPTY,
        S_E_RD,
        S_E_MUL,
        S_E_DIV,
        S_E_OUT
    } ptu_state_t;

endpackage

`default_nettype wire

### design/ptu_if.sv
`default_nettype none

interface ptu_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [19:0] vel_x;
    logic signed [19:0] vel_y;
    logic [15:0]        life_span;
    logic [15:0]        max_size;
    logic signed [15:0] spin_rate;
    logic [15:0]        start_angle;
    logic [23:0]        rgb_in;
    logic [11:0]        dt;

    modport source (output valid, req_type, pos_x, pos_y, vel_x, vel_y, life_span,
                    max_size, spin_rate, start_angle, rgb_in, dt, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, vel_x, vel_y, life_span,
                  max_size, spin_rate, start_angle, rgb_in, dt, output ready);
endinterface

interface ptu_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic [15:0]        out_radius;
    logic [15:0]        out_angle;
    logic [23:0]        rgb_out;
    logic [7:0]         alpha;
    logic               last;
    logic [6:0]         live_count;

    modport source (output valid, kind, out_x, out_y, out_radius, out_angle, rgb_out,
                    alpha, last, live_count, input ready);
    modport sink (input valid, kind, out_x, out_y, out_radius, out_angle, rgb_out,
                  alpha, last, live_count, output ready);
endinterface

interface ptu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] damping;

    modport source (output valid, damping, input ready);
    modport sink (input valid, damping, output ready);
endinterface

`default_nettype wire

### design/ptu_ram.sv
`default_nettype none

module ptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/ptu_div.sv
`default_nettype none

// two restoring dividers side by side, one quotient bit per cycle
module ptu_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [32:0] num_r,
    input  wire logic [16:0] den_r,
    input  wire logic [23:0] num_a,
    input  wire logic [15:0] den_a,
    output logic             done,
    output logic [15:0]      q_radius,
    output logic [7:0]       q_alpha
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [32:0] rem_r_reg;
    logic [23:0] rem_a_reg;
    logic [16:0] dr_reg;
    logic [15:0] da_reg;
    logic [15:0] qr_reg;
    logic [15:0] qa_reg;

    logic [32:0] sh_r;
    logic [31:0] sh_a;
    logic        ge_r;
    logic        ge_a;

    assign sh_r = {16'd0, dr_reg} << cnt_reg;
    assign sh_a = {16'd0, da_reg} << cnt_reg;
    assign ge_r = rem_r_reg >= sh_r;
    assign ge_a = {8'd0, rem_a_reg} >= sh_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == 4'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd15;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_r_reg <= num_r;
            rem_a_reg <= num_a;
            dr_reg    <= den_r;
            da_reg    <= den_a;
            qr_reg    <= '0;
            qa_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (ge_r)
            begin
                rem_r_reg       <= rem_r_reg - sh_r;
                qr_reg[cnt_reg] <= 1'b1;
            end
            if (ge_a)
            begin
                rem_a_reg       <= rem_a_reg - sh_a[23:0];
                qa_reg[cnt_reg] <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign q_radius = qr_reg;
    assign q_alpha  = qa_reg[7:0];

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a finished run");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != 4'd0) |=> busy_reg)
        else $error("divider stopped early");
    a_alpha_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && {8'd0, da_reg} != 24'd0 && rem_a_reg < {8'd0, da_reg})
            |-> qa_reg[15:8] == 8'd0)
        else $error("alpha quotient overflow");
`endif

endmodule

`default_nettype wire

### design/particle_table_update.sv
`default_nettype none

// particle table: up to 64 particles held in one 192-bit wide synchronous ram.
// a spawn or clear gives one result with last set; a spawn into a full table
// is dropped. a tick on an empty table gives one empty result; else the first
// pass reads, ages, moves, damps, rotates and compacts every particle (read,
// multiply, write back). if none survive it gives one empty result, else a
// second pass reads each survivor, forms the radius and alpha with a 16-step
// serial divider and presents the record. the pace of a tick is set by the
// single ram port and the bit-serial divider. results sit in an output
// register, so one result may wait while the block carries on.
// damping may be written at any time the block is idle; cfg.ready stays high.
module particle_table_update (
    input  wire logic clk,
    input  wire logic rst_n,
    ptu_req_if.sink   req,
    ptu_rsp_if.source rsp,
    ptu_cfg_if.sink   cfg
);

    localparam int IW = ptu_pkg::IDX_W;
    localparam int CW = ptu_pkg::CNT_W;

    ptu_pkg::ptu_state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic [11:0]   dt_reg;
    logic [15:0]   damp_reg;

    // output register
    logic               rsp_valid_reg;
    ptu_pkg::ptu_rsp_t  rsp_reg;
    ptu_pkg::ptu_rsp_t  rsp_next;
    logic               rsp_load;
    logic               slot_free;

    // ram port
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    ptu_pkg::ptu_entry_t          ram_wdata;
    logic [IW-1:0]                ram_raddr;
    logic [ptu_pkg::ENTRY_W-1:0]  ram_rdata;
    ptu_pkg::ptu_entry_t          ent;

    // tick pass: multiply stage
    ptu_pkg::ptu_entry_t upd_reg;
    ptu_pkg::ptu_entry_t upd_next;
    logic signed [20:0]  dx_reg;
    logic signed [20:0]  dy_reg;
    logic                alive_reg;
    logic signed [12:0]  dt_s;
    logic signed [16:0]  damp_s;
    logic signed [32:0]  mx;
    logic signed [32:0]  my;
    logic signed [36:0]  dvx;
    logic signed [36:0]  dvy;
    logic signed [28:0]  ms;
    logic signed [24:0]  sum_x;
    logic signed [24:0]  sum_y;
    logic signed [23:0]  sat_x;
    logic signed [23:0]  sat_y;
    logic [CW-1:0]       n_plus;
    logic                pass_end;

    // emit pass
    logic signed [23:0] e_px_reg;
    logic signed [23:0] e_py_reg;
    logic [15:0]        e_angle_reg;
    logic [23:0]        e_colour_reg;
    logic               e_ok_reg;
    logic               e_last;
    logic [16:0]        diff_r;
    logic [32:0]        num_r;
    logic [23:0]        num_a;
    logic               div_start;
    logic               div_done;
    logic [15:0]        q_radius;
    logic [7:0]         q_alpha;

    logic req_acc;
    logic cfg_acc;

    assign req_acc   = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign ent = ptu_pkg::ptu_entry_t'(ram_rdata);

    ptu_ram #(
        .WIDTH (ptu_pkg::ENTRY_W),
        .DEPTH (ptu_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // tick arithmetic on the entry just read; floor by arithmetic shift
    assign dt_s   = signed'({1'b0, dt_reg});
    assign damp_s = signed'({1'b0, damp_reg});
    assign mx     = ent.vx * dt_s;
    assign my     = ent.vy * dt_s;
    assign dvx    = ent.vx * damp_s;
    assign dvy    = ent.vy * damp_s;
    assign ms     = ent.spin * dt_s;

    // aged, damped and rotated entry; position is moved in the write stage
    always_comb
    begin
        upd_next           = ent;
        upd_next.vx        = dvx[35:16];
        upd_next.vy        = dvy[35:16];
        upd_next.angle     = ent.angle + ms[27:12];
        upd_next.life_left = ent.life_left - {4'd0, dt_reg};
    end

    // move and saturate to the 24-bit position range
    assign sum_x = {upd_reg.px[23], upd_reg.px} + {{4{dx_reg[20]}}, dx_reg};
    assign sum_y = {upd_reg.py[23], upd_reg.py} + {{4{dy_reg[20]}}, dy_reg};
    assign sat_x = (sum_x[24] != sum_x[23]) ? (sum_x[24] ? 24'sh800000 : 24'sh7FFFFF)
                                            : sum_x[23:0];
    assign sat_y = (sum_y[24] != sum_y[23]) ? (sum_y[24] ? 24'sh800000 : 24'sh7FFFFF)
                                            : sum_y[23:0];

    assign n_plus   = n_reg + {{(CW-1){1'b0}}, alive_reg};
    assign pass_end = (idx_reg + 7'd1) == count_reg;

    // radius = size*(2*max - life) / (2*max), alpha = 255*life / max
    assign diff_r = {ent.life_max, 1'b0} - {1'b0, ent.life_left};
    assign num_r  = {17'd0, ent.size_max} * {16'd0, diff_r};
    assign num_a  = {8'd0, ent.life_left} * 24'd255;
    assign e_last = (idx_reg + 7'd1) == count_reg;

    ptu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_r    (num_r),
        .den_r    ({ent.life_max, 1'b0}),
        .num_a    (num_a),
        .den_a    (ent.life_max),
        .done     (div_done),
        .q_radius (q_radius),
        .q_alpha  (q_alpha)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptu_pkg::S_IDLE:
            begin
                if (req_acc && req.req_type == ptu_pkg::REQ_TICK && count_reg != '0)
                begin
                    state_next = ptu_pkg::S_T_RD;
                end
            end
            ptu_pkg::S_T_RD:  state_next = ptu_pkg::S_T_MUL;
            ptu_pkg::S_T_MUL: state_next = ptu_pkg::S_T_WR;
            ptu_pkg::S_T_WR:
            begin
                if (!pass_end)
                begin
                    state_next = ptu_pkg::S_T_RD;
                end
                else if (n_plus == '0)
                begin
                    state_next = ptu_pkg::S_EMPTY;
                end
                else
                begin
                    state_next = ptu_pkg::S_E_RD;
                end
            end
            ptu_pkg::S_EMPTY:
            begin
                if (slot_free)
                begin
                    state_next = ptu_pkg::S_IDLE;
                end
            end
            ptu_pkg::S_E_RD:  state_next = ptu_pkg::S_E_MUL;
            ptu_pkg::S_E_MUL: state_next = ptu_pkg::S_E_DIV;
            ptu_pkg::S_E_DIV:
            begin
                if (div_done)
                begin
                    state_next = ptu_pkg::S_E_OUT;
                end
            end
            ptu_pkg::S_E_OUT:
            begin
                if (slot_free)
                begin
                    state_next = e_last ? ptu_pkg::S_IDLE : ptu_pkg::S_E_RD;
                end
            end
            default: state_next = ptu_pkg::S_IDLE;
        endcase
    end

    // ram control, result loading and handshake
    always_comb
    begin
        req.ready  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[IW-1:0];
        ram_raddr  = idx_reg[IW-1:0];
        div_start  = 1'b0;
        rsp_load   = 1'b0;
        rsp_next   = '0;
        rsp_next.last = 1'b1;

        // spawn entry, taken straight from the request
        ram_wdata.px        = req.pos_x;
        ram_wdata.py        = req.pos_y;
        ram_wdata.vx        = req.vel_x;
        ram_wdata.vy        = req.vel_y;
        ram_wdata.life_left = req.life_span;
        ram_wdata.life_max  = req.life_span;
        ram_wdata.size_max  = req.max_size;
        ram_wdata.angle     = req.start_angle;
        ram_wdata.spin      = req.spin_rate;
        ram_wdata.colour    = req.rgb_in;

        case (state_reg)
            ptu_pkg::S_IDLE:
            begin
                req.ready = slot_free;
                if (req_acc)
                begin
                    case (req.req_type)
                        ptu_pkg::REQ_SPAWN:
                        begin
                            rsp_load = 1'b1;
                            if (count_reg >= CW'(ptu_pkg::CAPACITY))
                            begin
                                rsp_next.kind       = ptu_pkg::KIND_DROPPED;
                                rsp_next.live_count = count_reg;
                            end
                            else
                            begin
                                ram_we              = 1'b1;
                                rsp_next.kind       = ptu_pkg::KIND_SPAWNED;
                                rsp_next.live_count = count_reg + 7'd1;
                            end
                        end
                        ptu_pkg::REQ_CLEAR:
                        begin
                            rsp_load      = 1'b1;
                            rsp_next.kind = ptu_pkg::KIND_CLEARED;
                        end
                        ptu_pkg::REQ_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_load      = 1'b1;
                                rsp_next.kind = ptu_pkg::KIND_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ptu_pkg::S_T_WR:
            begin
                // compaction: survivors go down to slot n, never above the read slot
                ram_we              = alive_reg;
                ram_waddr           = n_reg[IW-1:0];
                ram_wdata           = upd_reg;
                ram_wdata.px        = sat_x;
                ram_wdata.py        = sat_y;
            end
            ptu_pkg::S_EMPTY:
            begin
                rsp_load      = slot_free;
                rsp_next.kind = ptu_pkg::KIND_EMPTY;
            end
            ptu_pkg::S_E_MUL:
            begin
                div_start = 1'b1;
            end
            ptu_pkg::S_E_OUT:
            begin
                rsp_load            = slot_free;
                rsp_next.kind       = ptu_pkg::KIND_RECORD;
                rsp_next.out_x      = e_px_reg;
                rsp_next.out_y      = e_py_reg;
                rsp_next.out_radius = e_ok_reg ? q_radius : 16'd0;
                rsp_next.out_angle  = e_angle_reg;
                rsp_next.rgb_out    = e_colour_reg;
                rsp_next.alpha      = e_ok_reg ? q_alpha : 8'd0;
                rsp_next.last       = e_last;
                rsp_next.live_count = count_reg;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptu_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            damp_reg      <= ptu_pkg::DAMP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                damp_reg <= cfg.damping;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                ptu_pkg::S_IDLE:
                begin
                    if (req_acc)
                    begin
                        idx_reg <= '0;
                        n_reg   <= '0;
                        if (req.req_type == ptu_pkg::REQ_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        else if (req.req_type == ptu_pkg::REQ_SPAWN &&
                                 count_reg < CW'(ptu_pkg::CAPACITY))
                        begin
                            count_reg <= count_reg + 7'd1;
                        end
                    end
                end
                ptu_pkg::S_T_WR:
                begin
                    n_reg <= n_plus;
                    if (pass_end)
                    begin
                        idx_reg   <= '0;
                        count_reg <= n_plus;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 7'd1;
                    end
                end
                ptu_pkg::S_E_OUT:
                begin
                    if (slot_free)
                    begin
                        idx_reg <= idx_reg + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
        if (state_reg == ptu_pkg::S_IDLE && req_acc)
        begin
            dt_reg <= req.dt;
        end
        if (state_reg == ptu_pkg::S_T_MUL)
        begin
            upd_reg   <= upd_next;
            dx_reg    <= mx[32:12];
            dy_reg    <= my[32:12];
            alive_reg <= ent.life_left > {4'd0, dt_reg};
        end
        if (state_reg == ptu_pkg::S_E_MUL)
        begin
            e_px_reg     <= ent.px;
            e_py_reg     <= ent.py;
            e_angle_reg  <= ent.angle;
            e_colour_reg <= ent.colour;
            e_ok_reg     <= (ent.life_max != 16'd0) && (ent.life_left <= ent.life_max);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.kind       = rsp_reg.kind;
    assign rsp.out_x      = rsp_reg.out_x;
    assign rsp.out_y      = rsp_reg.out_y;
    assign rsp.out_radius = rsp_reg.out_radius;
    assign rsp.out_angle  = rsp_reg.out_angle;
    assign rsp.rgb_out    = rsp_reg.rgb_out;
    assign rsp.alpha      = rsp_reg.alpha;
    assign rsp.last       = rsp_reg.last;
    assign rsp.live_count = rsp_reg.live_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ptu_pkg::CAPACITY))
        else $error("particle count above capacity");
    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptu_pkg::S_T_WR) |-> n_reg <= idx_reg)
        else $error("compaction write ahead of read");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_next.kind == ptu_pkg::KIND_CLEARED) |=> count_reg == '0)
        else $error("clear left particles behind");
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ptu_pkg::S_E_DIV)
        else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire
